// File: design/sobel_pkg.sv
// Shared constants, register codes and types of the Sobel edge threshold block.
package sobel_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int PIX_W      = 8;
  localparam int POS_OUT_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int THR_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDE_MODE    = 2'd3;

  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH    = 12'd640;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT   = 12'd480;
  localparam logic [THR_W-1:0]      RST_EDGE_THRESHOLD = 8'd64;
  localparam logic                  RST_DIVIDE_MODE    = 1'b0;

  localparam logic [CFG_DATA_W-1:0] MIN_SIZE    = 12'd3;
  localparam logic [12:0]           RECIP_NINTH = 13'd7282;
  localparam logic [PIX_W-1:0]      EDGE_ON     = 8'd255;
  localparam logic [PIX_W-1:0]      EDGE_OFF    = 8'd0;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } sobel_col_t;

  typedef struct packed {
    logic                 last;
    logic [POS_OUT_W-1:0] center_row;
    logic [POS_OUT_W-1:0] center_column;
  } sobel_tag_t;

endpackage

// File: design/sobel_if.sv
// Channel interfaces for pixels, results and configuration writes.
interface sobel_pix_if import sobel_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source(output valid, pixel, frame_start, input ready);
  modport sink(input valid, pixel, frame_start, output ready);
endinterface

interface sobel_res_if import sobel_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     edge_value;
  logic [POS_OUT_W-1:0] center_row;
  logic [POS_OUT_W-1:0] center_column;
  logic                 frame_last;

  modport source(output valid, edge_value, center_row, center_column, frame_last,
                 input ready);
  modport sink(input valid, edge_value, center_row, center_column, frame_last,
               output ready);
endinterface

interface sobel_cfg_if import sobel_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: design/sobel_edge_threshold.sv
// Top level of the streaming 3x3 Sobel edge detector with threshold.
//
//   channel  role    payload
//   pix      sink    pixel, frame_start
//   res      source  edge_value, center_row, center_column, frame_last
//   cfg      sink    index, data (always ready)
//
// One pixel is taken per cycle while no result is held.
// The line memory read and its write-back of the same column are one stage
// apart, with a bypass when consecutive pixels hit the same column.
// Reset restores the register defaults and clears position, window and valids.
// When a result is held, every stage and the pixel input stall together.
module sobel_edge_threshold import sobel_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input logic         clk,
  input logic         rst,
  sobel_pix_if.sink   pix,
  sobel_res_if.source res,
  sobel_cfg_if.sink   cfg
);

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int POS_MAX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CMP_W     = ((POS_MAX_W > CFG_DATA_W) ? POS_MAX_W : CFG_DATA_W) + 1;

  logic [CFG_DATA_W-1:0] image_width, image_height;
  logic [THR_W-1:0]      edge_threshold;
  logic                  divide_mode;

  logic [COL_W-1:0] col_pos, col_cur;
  logic [ROW_W-1:0] row_pos, row_cur;
  logic [CMP_W-1:0] width_lim, height_lim;
  logic             last_col, last_row, emit, en, accept;
  sobel_tag_t       tag_cur;

  logic             v1, emit1;
  logic [PIX_W-1:0] pix1;
  logic [COL_W-1:0] idx1;
  sobel_tag_t       tag1;
  logic [PIX_W-1:0] rd_upper, rd_middle;
  sobel_col_t       cur_col, center_col, left_col;
  sobel_tag_t       out_tag;
  logic [PIX_W-1:0] out_edge;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      edge_threshold <= RST_EDGE_THRESHOLD;
      divide_mode    <= RST_DIVIDE_MODE;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_IMAGE_WIDTH:    image_width    <= cfg.data;
        REG_IMAGE_HEIGHT:   image_height   <= cfg.data;
        REG_EDGE_THRESHOLD: edge_threshold <= cfg.data[THR_W-1:0];
        REG_DIVIDE_MODE:    divide_mode    <= cfg.data[0];
      endcase
    end
  end

  assign en        = !res.valid || res.ready;
  assign pix.ready = en;
  assign accept    = pix.valid && en;

  always_comb begin
    if (image_width < MIN_SIZE) begin
      width_lim = CMP_W'(MIN_SIZE);
    end else if (CMP_W'(image_width) > CMP_W'(MAX_WIDTH)) begin
      width_lim = CMP_W'(MAX_WIDTH);
    end else begin
      width_lim = CMP_W'(image_width);
    end
    if (image_height < MIN_SIZE) begin
      height_lim = CMP_W'(MIN_SIZE);
    end else if (CMP_W'(image_height) > CMP_W'(MAX_HEIGHT)) begin
      height_lim = CMP_W'(MAX_HEIGHT);
    end else begin
      height_lim = CMP_W'(image_height);
    end
    col_cur  = pix.frame_start ? '0 : col_pos;
    row_cur  = pix.frame_start ? '0 : row_pos;
    last_col = (CMP_W'(col_cur) + CMP_W'(1)) >= width_lim;
    last_row = (CMP_W'(row_cur) + CMP_W'(1)) >= height_lim;
    emit     = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
    tag_cur.last          = last_col && last_row;
    tag_cur.center_row    = POS_OUT_W'(row_cur - ROW_W'(1));
    tag_cur.center_column = POS_OUT_W'(col_cur - COL_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_pos <= '0;
        row_pos <= last_row ? '0 : row_cur + ROW_W'(1);
      end else begin
        col_pos <= col_cur + COL_W'(1);
        row_pos <= row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix1  <= pix.pixel;
      idx1  <= col_cur;
      tag1  <= tag_cur;
      emit1 <= emit;
    end
  end

  sobel_line_store #(
    .DEPTH(MAX_WIDTH),
    .AW   (COL_W)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (en),
    .rd_addr  (col_cur),
    .wr_en    (en && v1),
    .wr_addr  (idx1),
    .wr_upper (rd_middle),
    .wr_middle(pix1),
    .rd_upper (rd_upper),
    .rd_middle(rd_middle)
  );

  assign cur_col.top = rd_upper;
  assign cur_col.mid = rd_middle;
  assign cur_col.bot = pix1;

  sobel_col_cell u_cell_center (
    .clk    (clk),
    .rst    (rst),
    .shift  (en && v1),
    .col_in (cur_col),
    .col_out(center_col)
  );

  sobel_col_cell u_cell_left (
    .clk    (clk),
    .rst    (rst),
    .shift  (en && v1),
    .col_in (center_col),
    .col_out(left_col)
  );

  sobel_grad u_grad (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (v1 && emit1),
    .in_tag        (tag1),
    .left          (left_col),
    .center        (center_col),
    .right         (cur_col),
    .edge_threshold(edge_threshold),
    .divide_mode   (divide_mode),
    .out_valid     (res.valid),
    .out_tag       (out_tag),
    .out_edge      (out_edge)
  );

  assign res.edge_value    = out_edge;
  assign res.center_row    = out_tag.center_row;
  assign res.center_column = out_tag.center_column;
  assign res.frame_last    = out_tag.last;

endmodule

// File: design/sobel_line_store.sv
// Upper and middle line memories with registered read and write-to-read bypass.
module sobel_line_store import sobel_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEF_MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_upper,
  input  logic [PIX_W-1:0] wr_middle,
  output logic [PIX_W-1:0] rd_upper,
  output logic [PIX_W-1:0] rd_middle
);

  logic [PIX_W-1:0] upper_mem [DEPTH];
  logic [PIX_W-1:0] middle_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_upper  <= wr_upper;
        rd_middle <= wr_middle;
      end else begin
        rd_upper  <= upper_mem[rd_addr];
        rd_middle <= middle_mem[rd_addr];
      end
    end
  end

endmodule

// File: design/sobel_col_cell.sv
// One window column cell: holds three pixels and passes them on at each shift.
module sobel_col_cell import sobel_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       shift,
  input  sobel_col_t col_in,
  output sobel_col_t col_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_out <= '0;
    end else if (shift) begin
      col_out <= col_in;
    end
  end

endmodule

// File: design/sobel_grad.sv
// Gradient, one-ninth scaling and squared-magnitude threshold pipeline.
module sobel_grad import sobel_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  sobel_tag_t       in_tag,
  input  sobel_col_t       left,
  input  sobel_col_t       center,
  input  sobel_col_t       right,
  input  logic [THR_W-1:0] edge_threshold,
  input  logic             divide_mode,
  output logic             out_valid,
  output sobel_tag_t       out_tag,
  output logic [PIX_W-1:0] out_edge
);

  logic [9:0]         sum_left, sum_right, sum_top, sum_bot;
  logic signed [10:0] gx, gy;
  logic               va, vb;
  sobel_tag_t         tag_a, tag_b;
  logic signed [10:0] gx_a, gy_a;
  logic [9:0]         abs_x, abs_y;
  logic [22:0]        prod_x, prod_y;
  logic [6:0]         q_x, q_y;
  logic               up_x, up_y;
  logic [6:0]         sx, sy;
  logic [13:0]        sq_x, sq_y;
  logic [14:0]        mag;
  logic [15:0]        th_sq;

  always_comb begin
    sum_left  = 10'(left.top) + 10'(left.bot) + {1'b0, left.mid, 1'b0};
    sum_right = 10'(right.top) + 10'(right.bot) + {1'b0, right.mid, 1'b0};
    sum_top   = 10'(left.top) + 10'(right.top) + {1'b0, center.top, 1'b0};
    sum_bot   = 10'(left.bot) + 10'(right.bot) + {1'b0, center.bot, 1'b0};
    gx        = signed'({1'b0, sum_left}) - signed'({1'b0, sum_right});
    gy        = signed'({1'b0, sum_top}) - signed'({1'b0, sum_bot});
  end

  always_comb begin
    abs_x  = gx_a[10] ? 10'(-gx_a) : 10'(gx_a);
    abs_y  = gy_a[10] ? 10'(-gy_a) : 10'(gy_a);
    prod_x = 23'(abs_x) * 23'(RECIP_NINTH);
    prod_y = 23'(abs_y) * 23'(RECIP_NINTH);
  end

  // Truncation toward zero takes the floor of the magnitude; the shifted
  // multiply rounds negative values away from zero.
  always_comb begin
    sx   = q_x + 7'(up_x);
    sy   = q_y + 7'(up_y);
    sq_x = 14'(sx) * 14'(sx);
    sq_y = 14'(sy) * 14'(sy);
    mag  = 15'(sq_x) + 15'(sq_y);
  end

  always_ff @(posedge clk) begin
    th_sq <= 16'(edge_threshold) * 16'(edge_threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx_a     <= gx;
      gy_a     <= gy;
      tag_a    <= in_tag;
      q_x      <= prod_x[22:16];
      q_y      <= prod_y[22:16];
      up_x     <= divide_mode && gx_a[10] && (prod_x[15:0] != 16'd0);
      up_y     <= divide_mode && gy_a[10] && (prod_y[15:0] != 16'd0);
      tag_b    <= tag_a;
      out_tag  <= tag_b;
      out_edge <= ({1'b0, mag} > th_sq) ? EDGE_ON : EDGE_OFF;
    end
  end

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the streaming Sobel edge threshold block.
`timescale 1ns / 1ps

module tb_top import sobel_pkg::*; ();

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_PAUSE = 12;
  localparam int PRINT_LIMIT = 100;

  typedef enum int {
    PAT_NOISE,
    PAT_BINARY,
    PAT_STRIPES,
    PAT_FLAT,
    PAT_LEFT_BRIGHT,
    PAT_CORNER_BRIGHT
  } pixel_pattern_t;

  typedef struct {
    logic [PIX_W-1:0]     edge_value;
    logic [POS_OUT_W-1:0] center_row;
    logic [POS_OUT_W-1:0] center_column;
    logic                 frame_last;
  } edge_result_t;

  logic clk;
  logic rst;

  sobel_pix_if pix ();
  sobel_res_if res ();
  sobel_cfg_if cfg ();

  sobel_edge_threshold u_dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  logic [THR_W-1:0]      threshold_reg;
  logic                  divide_reg;

  logic [PIX_W-1:0] upper_line [DEF_MAX_WIDTH];
  logic [PIX_W-1:0] middle_line [DEF_MAX_WIDTH];
  logic [PIX_W-1:0] win [6];
  int unsigned      col_pos;
  int unsigned      row_pos;

  edge_result_t expected_edges [$];

  int error_count = 0;
  int quiet_cycles = 0;
  int pixels_sent = 0;
  int hold_request = 0;
  bit source_idle_on = 1'b0;
  bit sink_idle_on = 1'b0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int unsigned size_limit(logic [CFG_DATA_W-1:0] v, int unsigned hi);
    if (v < MIN_SIZE) return 32'(MIN_SIZE);
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic int scale_ninth(int g);
    if (divide_reg == 1'b0) return g / 9;
    return (g * int'(RECIP_NINTH)) >>> 16;
  endfunction

  function automatic logic [PIX_W-1:0] gen_pixel(pixel_pattern_t pat, int c, int r);
    case (pat)
      PAT_NOISE: return PIX_W'($urandom_range(0, 255));
      PAT_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      PAT_STRIPES: begin
        if (((c + r) / 2) % 2 == 1) return PIX_W'($urandom_range(200, 255));
        return PIX_W'($urandom_range(0, 55));
      end
      PAT_FLAT: return 8'h00;
      PAT_LEFT_BRIGHT: return (c == 0) ? 8'hFF : ((c == 1) ? 8'h80 : 8'h00);
      default: return (c == 2 || r == 2) ? 8'hFF : 8'h00;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (error_count < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic predict_edge(logic [PIX_W-1:0] bot, logic fs);
    int unsigned w, h, col, row, idx;
    int l0, l1, l2, c0, c2, r0, r1, r2, gx, gy, sx, sy;
    logic [PIX_W-1:0] top, mid;
    bit last_col, last_row;
    edge_result_t want;
    w = size_limit(width_reg, DEF_MAX_WIDTH);
    h = size_limit(height_reg, DEF_MAX_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    col = col_pos;
    row = row_pos;
    idx = col % DEF_MAX_WIDTH;
    top = upper_line[idx];
    mid = middle_line[idx];
    last_col = (col + 1 >= w);
    last_row = (row + 1 >= h);
    if (row >= 2 && col >= 2) begin
      l0 = int'(win[0]);
      l1 = int'(win[1]);
      l2 = int'(win[2]);
      c0 = int'(win[3]);
      c2 = int'(win[5]);
      r0 = int'(top);
      r1 = int'(mid);
      r2 = int'(bot);
      gx = (l0 + l2 + 2 * l1) - (r0 + r2 + 2 * r1);
      gy = (l0 + r0 + 2 * c0) - (l2 + r2 + 2 * c2);
      sx = scale_ninth(gx);
      sy = scale_ninth(gy);
      want.edge_value = (sx * sx + sy * sy > int'(threshold_reg) * int'(threshold_reg)) ?
                        EDGE_ON : EDGE_OFF;
      want.center_row = POS_OUT_W'(row - 1);
      want.center_column = POS_OUT_W'(col - 1);
      want.frame_last = last_col && last_row;
      expected_edges.push_back(want);
    end
    upper_line[idx] = mid;
    middle_line[idx] = bot;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = bot;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
  endtask

  task automatic check_edge_result();
    edge_result_t want;
    if (expected_edges.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected, row %0d column %0d",
                                res.center_row, res.center_column));
      return;
    end
    want = expected_edges.pop_front();
    if (res.edge_value !== want.edge_value)
      report_mismatch($sformatf("edge_value %0d, expected %0d at row %0d column %0d",
                                res.edge_value, want.edge_value,
                                want.center_row, want.center_column));
    if (res.center_row !== want.center_row)
      report_mismatch($sformatf("center_row %0d, expected %0d", res.center_row,
                                want.center_row));
    if (res.center_column !== want.center_column)
      report_mismatch($sformatf("center_column %0d, expected %0d", res.center_column,
                                want.center_column));
    if (res.frame_last !== want.frame_last)
      report_mismatch($sformatf("frame_last %0b, expected %0b at row %0d column %0d",
                                res.frame_last, want.frame_last,
                                want.center_row, want.center_column));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      threshold_reg = RST_EDGE_THRESHOLD;
      divide_reg = RST_DIVIDE_MODE;
      for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      expected_edges.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_IMAGE_WIDTH: width_reg = cfg.data;
          REG_IMAGE_HEIGHT: height_reg = cfg.data;
          REG_EDGE_THRESHOLD: threshold_reg = cfg.data[THR_W-1:0];
          REG_DIVIDE_MODE: divide_reg = cfg.data[0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) predict_edge(pix.pixel, pix.frame_start);
      if (res.valid && res.ready) check_edge_result();
    end
  end

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : result_sink
    int hold_left;
    res.ready = 1'b0;
    forever begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
        res.ready <= 1'b0;
        repeat (hold_left) @(posedge clk);
      end else if (sink_idle_on && $urandom_range(0, 11) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_pixel(logic [PIX_W-1:0] value, logic fs);
    if (source_idle_on && $urandom_range(0, 7) == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel <= value;
    pix.frame_start <= fs;
    do @(posedge clk); while (!pix.ready);
    pixels_sent++;
  endtask

  task automatic send_frame(int unsigned w, int unsigned count, pixel_pattern_t pat,
                            logic start);
    for (int unsigned i = 0; i < count; i++)
      send_pixel(gen_pixel(pat, int'(i % w), int'(i / w)), start && (i == 0));
  endtask

  task automatic send_noise(int unsigned count, logic start);
    for (int unsigned i = 0; i < count; i++)
      send_pixel(PIX_W'($urandom_range(0, 255)), start && (i == 0));
  endtask

  task automatic wait_results_done();
    pix.valid <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic set_config(int unsigned wr, int unsigned hr, int unsigned thr, logic mode);
    wait_results_done();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(wr));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(hr));
    write_reg(REG_EDGE_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_DIVIDE_MODE, CFG_DATA_W'(mode));
    cfg.valid <= 1'b0;
  endtask

  task automatic test_directed_gradients();
    source_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    set_config(3, 3, 0, 1'b0);
    send_frame(3, 9, PAT_LEFT_BRIGHT, 1'b1);
    send_frame(3, 9, PAT_FLAT, 1'b1);
    set_config(3, 3, 0, 1'b1);
    send_frame(3, 9, PAT_CORNER_BRIGHT, 1'b1);
  endtask

  task automatic test_size_clamping();
    source_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    set_config(0, 1, 20, 1'b0);
    send_noise(9, 1'b1);
    set_config(2, 2, 5, 1'b1);
    send_noise(9, 1'b1);
    set_config(3, 4095, 30, 1'b0);
    send_noise(15, 1'b1);
  endtask

  // Shrinks the width while inside row 3 and the height while inside row 5.
  task automatic test_midframe_resize();
    source_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    set_config(10, 6, 25, 1'b0);
    send_noise(37, 1'b1);
    set_config(5, 6, 25, 1'b0);
    send_noise(6, 1'b0);
    set_config(5, 4, 25, 1'b0);
    send_noise(5, 1'b0);
  endtask

  task automatic test_output_backpressure();
    set_config(8, 8, 40, 1'b1);
    source_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    hold_request = 300;
    send_frame(8, 64, PAT_NOISE, 1'b1);
    wait_results_done();
  endtask

  task automatic test_random_frames(int target, bit idle);
    int start_count;
    int unsigned wr, hr, thr, w, h, total, cut;
    bit need_start;
    bit first;
    pixel_pattern_t pat;
    start_count = pixels_sent;
    need_start = 1'b1;
    first = 1'b1;
    sink_idle_on = idle;
    wr = 3;
    hr = 3;
    while (pixels_sent - start_count < target) begin
      if (first || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0: wr = $urandom_range(0, 2);
          1: wr = $urandom_range(13, 64);
          default: wr = $urandom_range(3, 12);
        endcase
        case ($urandom_range(0, 9))
          0: hr = $urandom_range(0, 2);
          1: hr = $urandom_range(9, 20);
          default: hr = $urandom_range(3, 8);
        endcase
        thr = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 48) : $urandom_range(0, 255);
        set_config(wr, hr, thr, 1'($urandom_range(0, 1)));
        first = 1'b0;
      end
      w = size_limit(CFG_DATA_W'(wr), DEF_MAX_WIDTH);
      h = size_limit(CFG_DATA_W'(hr), DEF_MAX_HEIGHT);
      pat = pixel_pattern_t'($urandom_range(0, 3));
      source_idle_on = idle && ($urandom_range(0, 3) != 0);
      total = w * h;
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : total;
      send_frame(w, cut, pat, need_start || ($urandom_range(0, 1) != 0));
      need_start = (cut != total);
    end
  endtask

  initial begin
    rst = 1'b1;
    pix.valid = 1'b0;
    pix.pixel = '0;
    pix.frame_start = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_gradients();
    test_size_clamping();
    test_midframe_resize();
    test_output_backpressure();
    test_random_frames(1700, 1'b1);
    test_random_frames(300, 1'b0);
    wait_results_done();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
